// ----- design/indexed_insert_remove_list_assert.svh -----
// assertion macros used by the list controller
`ifndef INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH

// condition holds at every clock edge out of reset
`define IIRL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IIRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define IIRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/iirl_pkg.sv -----
`timescale 1ns / 1ps

package iirl_pkg;

  // list geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned POS_W     = $clog2(DEPTH);
  localparam int unsigned FILL_W    = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W     = FILL_W;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     index;
    logic [WORD_BITS-1:0] value;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [WORD_BITS-1:0] read_value;
    logic [POS_W-1:0]     position;
    logic [FILL_W-1:0]    fill_level;
  } out_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic                 load;
    logic                 step;
    logic                 ins;
    logic                 rem;
    logic                 srch;
    logic                 sel;
    logic [IDX_W-1:0]     idx;
    logic [FILL_W-1:0]    held;
    logic [WORD_BITS-1:0] value;
  } cmd_t;

  // result lane passed down the chain toward cell zero
  typedef struct packed {
    logic                 hit;
    logic [POS_W-1:0]     pos;
    logic [WORD_BITS-1:0] data;
  } lane_t;

endpackage

// ----- design/iirl_cell.sv -----
`timescale 1ns / 1ps

module iirl_cell import iirl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [POS_W-1:0]     cell_pos_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  input  lane_t                lane_i,
  output logic [WORD_BITS-1:0] word_o,
  output lane_t                lane_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic                 hit_q, hit_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [WORD_BITS-1:0] data_q, data_d;
  logic [FILL_W-1:0]    pos_ext;
  logic                 own_hit;

  assign pos_ext = FILL_W'(cell_pos_i);

  // entry update: insert shifts up from the left, remove pulls down from the right
  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (pos_ext == cmd_i.idx) begin
        word_d = cmd_i.value;
      end else if (pos_ext > cmd_i.idx && pos_ext <= cmd_i.held) begin
        word_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (pos_ext >= cmd_i.idx && (pos_ext + FILL_W'(1)) < cmd_i.held) begin
        word_d = right_i;
      end
    end
  end

  // local hit: indexed select or key match inside the fill level
  assign own_hit = (cmd_i.sel && pos_ext == cmd_i.idx)
                || (cmd_i.srch && pos_ext < cmd_i.held && word_q == cmd_i.value);

  // result lane: load own hit, then keep a hit or take the neighbor's lane
  always_comb begin
    hit_d  = hit_q;
    pos_d  = pos_q;
    data_d = data_q;
    if (cmd_i.load) begin
      hit_d  = own_hit;
      pos_d  = cell_pos_i;
      data_d = word_q;
    end else if (cmd_i.step && !hit_q) begin
      hit_d  = lane_i.hit;
      pos_d  = lane_i.pos;
      data_d = lane_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pos_q  <= pos_d;
    data_q <= data_d;
  end

  assign word_o      = word_q;
  assign lane_o.hit  = hit_q;
  assign lane_o.pos  = pos_q;
  assign lane_o.data = data_q;

endmodule

// ----- design/iirl_ctrl.sv -----
`timescale 1ns / 1ps

module iirl_ctrl import iirl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  in_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o,
  output cmd_t  cmd_o,
  input  lane_t lane_i
);

  `include "indexed_insert_remove_list_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;
  logic [FILL_W-1:0] held_q, held_d;
  status_e           pend_st_q, pend_st_d;
  logic              pend_srch_q, pend_srch_d;
  logic              pend_rd_q, pend_rd_d;
  logic [FILL_W-1:0] pend_fill_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, res;

  logic              in_acc, done_go, full;
  logic              dec_scan, dec_srch, dec_rd, dec_ins, dec_rem;
  status_e           dec_st;
  logic [IDX_W-1:0]  dec_idx;
  logic [FILL_W-1:0] dec_held;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign full       = (held_q == FILL_W'(DEPTH));

  // operation decode against the current fill level
  always_comb begin
    dec_st   = ST_OK;
    dec_scan = 1'b0;
    dec_srch = 1'b0;
    dec_rd   = 1'b0;
    dec_ins  = 1'b0;
    dec_rem  = 1'b0;
    dec_idx  = in_data_i.index;
    dec_held = held_q;
    unique case (in_data_i.op)
      OP_APPEND: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_ins  = 1'b1;
          dec_idx  = held_q;
          dec_held = held_q + FILL_W'(1);
        end
      end
      OP_INSERT: begin
        if (in_data_i.index > held_q) begin
          dec_st = ST_RANGE;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_ins  = 1'b1;
          dec_held = held_q + FILL_W'(1);
        end
      end
      OP_REMOVE: begin
        if (in_data_i.index >= held_q) begin
          dec_st = ST_RANGE;
        end else begin
          dec_rem  = 1'b1;
          dec_rd   = 1'b1;
          dec_scan = 1'b1;
          dec_held = held_q - FILL_W'(1);
        end
      end
      OP_READ: begin
        if (in_data_i.index >= held_q) begin
          dec_st = ST_RANGE;
        end else begin
          dec_rd   = 1'b1;
          dec_scan = 1'b1;
        end
      end
      OP_SEARCH: begin
        dec_srch = 1'b1;
        dec_scan = 1'b1;
      end
      default: begin
        dec_st = ST_RANGE;
      end
    endcase
  end

  // command broadcast to the cell chain
  always_comb begin
    cmd_o.load  = in_acc;
    cmd_o.step  = (state_q == ST_SCAN);
    cmd_o.ins   = in_acc && dec_ins;
    cmd_o.rem   = in_acc && dec_rem;
    cmd_o.srch  = dec_srch;
    cmd_o.sel   = dec_rd;
    cmd_o.idx   = dec_idx;
    cmd_o.held  = held_q;
    cmd_o.value = in_data_i.value;
  end

  // result assembly from the lane that reached cell zero
  always_comb begin
    res.status     = pend_srch_q ? (lane_i.hit ? ST_OK : ST_MISS) : pend_st_q;
    res.read_value = (pend_rd_q && lane_i.hit) ? lane_i.data : '0;
    res.position   = (pend_srch_q && lane_i.hit) ? lane_i.pos : '0;
    res.fill_level = pend_fill_q;
  end

  assign done_go = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer: idle, lane scan, result handoff
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          state_d = dec_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + POS_W'(1);
        if (cnt_q == POS_W'(DEPTH - 2)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // pending result fields and fill level
  always_comb begin
    held_d      = held_q;
    pend_st_d   = pend_st_q;
    pend_srch_d = pend_srch_q;
    pend_rd_d   = pend_rd_q;
    if (in_acc) begin
      held_d      = dec_held;
      pend_st_d   = dec_st;
      pend_srch_d = dec_srch;
      pend_rd_d   = dec_rd;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (done_go) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      held_q      <= '0;
      pend_st_q   <= ST_OK;
      pend_srch_q <= 1'b0;
      pend_rd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      pend_st_q   <= pend_st_d;
      pend_srch_q <= pend_srch_d;
      pend_rd_q   <= pend_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_fill_q <= dec_held;
    end
    if (done_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `IIRL_ASSERT(a_held_bound, held_q <= FILL_W'(DEPTH), "fill level beyond depth")
  `IIRL_ASSERT_NXT(a_held_quiet, !in_acc, $stable(held_q), "fill level moved without transaction")
  `IIRL_ASSERT_IMP(a_scan_cnt, state_q == ST_SCAN, cnt_q <= POS_W'(DEPTH - 2),
                   "lane scan overran the chain")
  `IIRL_ASSERT_NXT(a_rd_hit, done_go && pend_rd_q, out_valid_q && out_q.status == ST_OK,
                   "indexed read left without a hit")

endmodule

// ----- design/indexed_insert_remove_list.sv -----
// append, insert and every rejected transaction go from accept straight to the result handoff
// read, remove and search first run a lane scan, then hand off the result
// the scan is the result lane walking down the cell chain, one cell per cycle
// a new transaction is taken only in idle, one in flight at a time; a stalled output holds the handoff
// reset clears the fill level and the sequencer; list entries are left unwritten
`timescale 1ns / 1ps

module indexed_insert_remove_list import iirl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t                 cmd;
  logic [WORD_BITS-1:0] word_w [DEPTH];
  lane_t                lane_w [DEPTH+1];

  // nothing enters the lane above the last cell
  assign lane_w[DEPTH] = '0;

  iirl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .lane_i      (lane_w[0])
  );

  // chain of list cells, neighbors linked both ways
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = word_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = word_w[i+1];
    end

    iirl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cell_pos_i (POS_W'(i)),
      .left_i     (left_w),
      .right_i    (right_w),
      .lane_i     (lane_w[i+1]),
      .word_o     (word_w[i]),
      .lane_o     (lane_w[i])
    );
  end

endmodule

// ----- bench/list_result_checker.sv -----
`timescale 1ns / 1ps

module list_result_checker import iirl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned ok_o,
  output int unsigned full_o,
  output int unsigned range_o,
  output int unsigned miss_o
);

  // predicted list contents and fill level
  logic [WORD_BITS-1:0] list_words [DEPTH];
  int unsigned          list_fill;

  // results predicted but not yet seen on the output channel
  out_t pending_results [$];

  int unsigned n_fail, n_results, n_ok, n_full, n_range, n_miss;

  // apply one transaction to the predicted list, return its result
  function automatic out_t list_apply(in_t t);
    out_t        r;
    int unsigned k;
    bit          found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (t.op)
      OP_APPEND: begin
        if (list_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_fill] = t.value;
          list_fill++;
        end
      end
      OP_INSERT: begin
        // the range test wins over the full test
        if (t.index > list_fill) begin
          r.status = ST_RANGE;
        end else if (list_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_fill; k > t.index; k--) list_words[k] = list_words[k-1];
          list_words[t.index] = t.value;
          list_fill++;
        end
      end
      OP_REMOVE: begin
        if (t.index >= list_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_words[t.index];
          list_fill--;
          for (k = t.index; k < list_fill; k++) list_words[k] = list_words[k+1];
        end
      end
      OP_READ: begin
        if (t.index >= list_fill) r.status = ST_RANGE;
        else r.read_value = list_words[t.index];
      end
      OP_SEARCH: begin
        r.status = ST_MISS;
        for (k = 0; k < list_fill; k++) begin
          if (!found && list_words[k] == t.value) begin
            found = 1'b1;
            r.status = ST_OK;
            r.position = POS_W'(k);
          end
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.fill_level = FILL_W'(list_fill);
    return r;
  endfunction

  // watch both channels, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want, got;
    if (!rst_ni) begin
      list_fill = 0;
      for (int i = 0; i < DEPTH; i++) list_words[i] = '0;
      pending_results.delete();
      n_fail = 0;
      n_results = 0;
      n_ok = 0;
      n_full = 0;
      n_range = 0;
      n_miss = 0;
    end else begin
      if (in_valid_i && !in_stall_i) pending_results.push_back(list_apply(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (pending_results.size() == 0) begin
          $error("result with no transaction waiting for it: %h", got);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          n_results++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_fail++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            n_fail++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            n_fail++;
          end
          if (got.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", want.fill_level, got.fill_level);
            n_fail++;
          end
          case (want.status)
            ST_OK:    n_ok++;
            ST_FULL:  n_full++;
            ST_RANGE: n_range++;
            default:  n_miss++;
          endcase
        end
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= pending_results.size();
    results_o    <= n_results;
    ok_o         <= n_ok;
    full_o       <= n_full;
    range_o      <= n_range;
    miss_o       <= n_miss;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import iirl_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 4;

  // op codes the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  int unsigned fails, pending, results, n_ok, n_full, n_range, n_miss;

  // stimulus bookkeeping
  int unsigned          sent       = 0;
  int unsigned          burst_left = 0;
  int unsigned          level      = 0;
  logic [WORD_BITS-1:0] word_pool [8];
  int unsigned          pool_next  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_insert_remove_list dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  list_result_checker u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .results_o    (results),
    .ok_o         (n_ok),
    .full_o       (n_full),
    .range_o      (n_range),
    .miss_o       (n_miss)
  );

  // receiver back-pressure in randomly chosen modes
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_run  = 0;

  always @(posedge clk) begin : rx_pattern
    logic hold;
    case (stall_mode)
      0:       hold = 1'b0;
      1:       hold = ($urandom_range(0, 3) == 0);
      2:       hold = ($urandom_range(0, 3) != 0);
      default: hold = !out_stall;
    endcase
    // cap stall runs so the watchdog limit stays meaningful
    if (stall_run >= 24) hold = 1'b0;
    out_stall <= hold;
    stall_run <= hold ? stall_run + 1 : 0;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  // cycles since the last transaction on either channel
  int unsigned quiet = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  // present one transaction and hold it until accepted, then maybe pause
  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [WORD_BITS-1:0] word);
    in_t t;
    t.op    = op;
    t.index = idx;
    t.value = word;
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    // track the fill level loosely to aim indexes at live entries
    case (op)
      OP_APPEND: begin
        if (level < DEPTH) level++;
      end
      OP_INSERT: begin
        if (idx <= level && level < DEPTH) level++;
      end
      OP_REMOVE: begin
        if (idx < level) level--;
      end
      default: ;
    endcase
    if (op == OP_APPEND || op == OP_INSERT) begin
      word_pool[pool_next] = word;
      pool_next = (pool_next + 1) % 8;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // mostly fresh words, some extremes, some repeats to make duplicates
  function automatic logic [WORD_BITS-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 5) return word_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // empty list, unknown op, fill to the top, then the full and end cases
  task automatic run_directed();
    issue(OP_READ, '0, '0);
    issue(OP_REMOVE, '0, '0);
    issue(OP_SEARCH, '0, '0);
    issue(OP_INSERT, IDX_W'(1), 32'h1234_5678);
    issue(OP_UNUSED_HI, '1, '1);
    issue(OP_INSERT, '0, '1);
    issue(OP_APPEND, '0, '0);
    for (int k = 0; k < DEPTH - 2; k++) issue(OP_APPEND, '0, $urandom());
    issue(OP_APPEND, '0, $urandom());
    issue(OP_INSERT, IDX_W'(DEPTH), $urandom());
    issue(OP_SEARCH, '0, '0);
    issue(OP_READ, IDX_W'(DEPTH - 1), '0);
    issue(OP_REMOVE, IDX_W'(DEPTH - 1), '0);
    issue(OP_REMOVE, '0, '0);
  endtask

  // random traffic in grow, shrink and mixed phases
  task automatic run_random();
    int unsigned          phase, roll, a, b, c, d;
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     idx;
    logic [WORD_BITS-1:0] word;
    phase = 2;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) phase = $urandom_range(0, 2);
      case (phase)
        0:       begin a = 30; b = 60; c = 70; d = 85; end
        1:       begin a = 8;  b = 16; c = 60; d = 78; end
        default: begin a = 20; b = 40; c = 60; d = 80; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else begin
        roll = $urandom_range(0, 99);
        if (roll < a) op = OP_APPEND;
        else if (roll < b) op = OP_INSERT;
        else if (roll < c) op = OP_REMOVE;
        else if (roll < d) op = OP_READ;
        else op = OP_SEARCH;
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) idx = IDX_W'($urandom_range(0, 31));
      else if (op == OP_INSERT) begin
        idx = (roll == 1) ? IDX_W'(level) : IDX_W'($urandom_range(0, level));
      end
      else if (level == 0) idx = '0;
      else begin
        idx = (roll == 1) ? IDX_W'(level - 1) : IDX_W'($urandom_range(0, level - 1));
      end
      if (op == OP_SEARCH && $urandom_range(0, 9) < 6) word = word_pool[$urandom_range(0, 7)];
      else word = pick_word();
      issue(op, idx, word);
    end
  endtask

  // stop sending, wait out the results, then watch for strays
  task automatic finish_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : main
    bit timed_out;
    timed_out = 1'b0;
    for (int i = 0; i < 8; i++) word_pool[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      begin
        run_directed();
        run_random();
        finish_stream();
      end
      begin
        wait (quiet >= IDLE_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;
    if (timed_out) $error("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    else if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("tb: %0d transactions sent, %0d results compared", sent, results);
    $display("tb: status ok %0d, full %0d, out of range %0d, not found %0d",
             n_ok, n_full, n_range, n_miss);
    if (!timed_out && pending == 0 && fails == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/iirl_pkg.sv
design/iirl_cell.sv
design/iirl_ctrl.sv
design/indexed_insert_remove_list.sv
bench/list_result_checker.sv
bench/tb.sv
